// ----- hdl/fpr_pkg.sv -----
// shared types and constants for the fp64 remainder block
package fpr_pkg;
   localparam int unsigned FRAC_BITS = 52;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
   localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

   // work description handed from the classifier to the execution unit
   typedef struct packed {
      logic        direct;    // result already known
      logic [63:0] result;    // result when direct
      logic        sign;
      logic [11:0] ex;        // biased exponent of x, 0 for subnormal
      logic [11:0] ey;
      logic [52:0] mx;        // significand, not yet normalised if subnormal
      logic [52:0] my;
   } job_type;
endpackage

// ----- hdl/fpr_stream_if.sv -----
// valid/ready channel carrying the operand pair or the remainder
interface fpr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] dividend_bits;
   logic [63:0] divisor_bits;
   modport source (output valid, output dividend_bits, output divisor_bits, input ready);
   modport sink (input valid, input dividend_bits, input divisor_bits, output ready);
endinterface

interface fpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] remainder_bits;
   modport source (output valid, output remainder_bits, input ready);
   modport sink (input valid, input remainder_bits, output ready);
endinterface

// ----- hdl/fp64_remainder.sv -----
// top level of the fp64 remainder block
// exponent difference sets the length of the loop, one shift-subtract a cycle
// subnormal operands are normalised before the loop, and the remainder is renormalised after it
// special cases (nan, infinite dividend, zero divisor, equal or smaller dividend) bypass the loop
// throughput: one transaction in the execution unit at a time, one more queued in front
// reset: synchronous, active high, clears control state only
module fp64_remainder (
   input logic clock,
   input logic reset,
   fpr_req_if.sink   req,
   fpr_rsp_if.source rsp
);
   logic             job_valid, job_ready;
   fpr_pkg::job_type job;

   fpr_front u_front (.clock, .reset, .req, .job_valid, .job_ready, .job);
   fpr_back  u_back  (.clock, .reset, .job_valid, .job_ready, .job, .rsp);
endmodule

// ----- hdl/fpr_front.sv -----
// operand classification and special case detection
module fpr_front (
   input  logic              clock,
   input  logic              reset,
   fpr_req_if.sink           req,
   output logic              job_valid,
   input  logic              job_ready,
   output fpr_pkg::job_type  job
);
   logic [10:0] ex, ey;
   logic [51:0] fx, fy;
   logic        x_nan, y_nan, invalid;
   logic [62:0] ax, ay;
   fpr_pkg::job_type job_in;
   logic        job_valid_ff;
   fpr_pkg::job_type job_ff;

   // field split
   always_comb begin
      ex = req.dividend_bits[62:52];
      ey = req.divisor_bits[62:52];
      fx = req.dividend_bits[51:0];
      fy = req.divisor_bits[51:0];
      ax = req.dividend_bits[62:0];
      ay = req.divisor_bits[62:0];
      x_nan = (ex == fpr_pkg::EXP_ALL_ONES) && (fx != '0);
      y_nan = (ey == fpr_pkg::EXP_ALL_ONES) && (fy != '0);
      invalid = (ay == '0) || y_nan || (ex == fpr_pkg::EXP_ALL_ONES);
   end

   // classification
   always_comb begin
      job_in.sign = req.dividend_bits[63];
      job_in.ex = {1'b0, ex};
      job_in.ey = {1'b0, ey};
      job_in.mx = {(ex != '0), fx};
      job_in.my = {(ey != '0), fy};
      job_in.direct = 1'b1;
      job_in.result = req.dividend_bits;
      if (invalid) begin
         if (x_nan) job_in.result = req.dividend_bits | fpr_pkg::QUIET_BIT;
         else if (y_nan) job_in.result = req.divisor_bits | fpr_pkg::QUIET_BIT;
         else job_in.result = fpr_pkg::DEFAULT_NAN;
      end else if (ax == ay) begin
         job_in.result = {req.dividend_bits[63], 63'd0};
      end else if (ax > ay) begin
         job_in.direct = 1'b0;
      end
   end

   assign req.ready = !job_valid_ff || job_ready;
   assign job_valid = job_valid_ff;
   assign job = job_ff;

   // one-entry queue towards the execution unit
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (req.ready) begin
         job_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         job_ff <= job_in;
      end
   end

   property p_hold;
      @(posedge clock) disable iff (reset) job_valid && !job_ready |=> job_valid && $stable(job);
   endproperty
   a_hold: assert property (p_hold) else $error("queued job changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> req.ready) else $error("empty queue refused a transaction");
   a_load: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> job_valid) else $error("accepted transaction lost");
endmodule

// ----- hdl/fpr_back.sv -----
// iterative shift-subtract remainder unit with result register
module fpr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  fpr_pkg::job_type  job,
   fpr_rsp_if.source         rsp
);
   typedef enum logic [2:0] {IDLE, NORM_X, NORM_Y, LOOP, FINAL, RENORM, PACK, DONE} state_type;
   state_type   state_ff, state_in;
   logic [63:0] mx_ff, mx_in, my_ff, my_in;
   logic signed [12:0] ex_ff, ex_in, ey_ff, ey_in;
   logic        sign_ff, sign_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] d;
   logic [12:0] sh;

   assign d = mx_ff - my_ff;
   assign sh = 13'(13'sd1 - ex_ff);
   assign job_ready = (state_ff == IDLE);
   assign rsp.valid = (state_ff == DONE);
   assign rsp.remainder_bits = res_ff;

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      mx_in = mx_ff; my_in = my_ff; ex_in = ex_ff; ey_in = ey_ff;
      sign_in = sign_ff; res_in = res_ff;
      case (state_ff)
         IDLE: if (job_valid) begin
            sign_in = job.sign;
            mx_in = {11'd0, job.mx};
            my_in = {11'd0, job.my};
            ex_in = (job.ex == '0) ? 13'sd1 : $signed({1'b0, job.ex});
            ey_in = (job.ey == '0) ? 13'sd1 : $signed({1'b0, job.ey});
            res_in = job.result;
            state_in = job.direct ? DONE : NORM_X;
         end
         NORM_X: if (mx_ff[52]) state_in = NORM_Y;
                 else begin mx_in = mx_ff << 1; ex_in = ex_ff - 13'sd1; end
         NORM_Y: if (my_ff[52]) state_in = LOOP;
                 else begin my_in = my_ff << 1; ey_in = ey_ff - 13'sd1; end
         LOOP: if (ex_ff > ey_ff) begin
            if (!d[63] && d == '0) begin
               res_in = {sign_ff, 63'd0}; state_in = DONE;
            end else begin
               mx_in = (!d[63] ? d : mx_ff) << 1;
               ex_in = ex_ff - 13'sd1;
            end
         end else state_in = FINAL;
         FINAL: begin
            if (!d[63] && d == '0) begin
               res_in = {sign_ff, 63'd0}; state_in = DONE;
            end else begin
               if (!d[63]) mx_in = d;
               state_in = RENORM;
            end
         end
         RENORM: if (mx_ff[52]) state_in = PACK;
                 else begin mx_in = mx_ff << 1; ex_in = ex_ff - 13'sd1; end
         PACK: begin
            if (ex_ff > 13'sd0)
               res_in = {sign_ff, ex_ff[10:0], mx_ff[51:0]};
            else if (sh >= 13'd64)
               res_in = {sign_ff, 63'd0};
            else
               res_in = {sign_ff, 63'(mx_ff >> sh[5:0])};
            state_in = DONE;
         end
         DONE: if (rsp.ready) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      mx_ff <= mx_in; my_ff <= my_in; ex_ff <= ex_in; ey_ff <= ey_in;
      sign_ff <= sign_in; res_ff <= res_in;
   end

   a_norm: assert property (@(posedge clock) disable iff (reset)
      state_ff == LOOP |-> my_ff[63:52] == 12'h001) else $error("divisor not normalised");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(res_ff)) else $error("result lost");
   a_mx: assert property (@(posedge clock) disable iff (reset)
      state_ff == LOOP |-> mx_ff[63:54] == '0) else $error("partial remainder overflow");
endmodule
